[hdl/pcf_pkg.sv]
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types, constants and helper functions of the pixel to channel fader.
// ----------------------------------------------------------------------------
package pcf_pkg;

  localparam int CHANNELS  = 512;
  localparam int CH_W      = $clog2(CHANNELS);
  localparam int START_W   = 9;
  localparam int OUT_IDX_W = 9;
  localparam int LVL_W     = 8;
  localparam int WORD_W    = 32;
  localparam int SH_W      = 5;
  localparam int TGT_N     = 4;
  localparam int K_W       = 2;
  localparam int ADDR_W    = 4;

  localparam logic [LVL_W-1:0] ALPHA_FULL = 8'hff;

  localparam logic [WORD_W-1:0] RED_MASK_RST   = 32'h00ff_0000;
  localparam logic [WORD_W-1:0] GREEN_MASK_RST = 32'h0000_ff00;
  localparam logic [WORD_W-1:0] BLUE_MASK_RST  = 32'h0000_00ff;

  typedef enum logic [1:0] {
    OP_GREY = 2'd0,
    OP_RGB  = 2'd1,
    OP_ARGB = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [WORD_W-1:0] red_bits;
    logic [WORD_W-1:0] green_bits;
    logic [WORD_W-1:0] blue_bits;
    logic [SH_W-1:0]   red_sh;
    logic [SH_W-1:0]   green_sh;
    logic [SH_W-1:0]   blue_sh;
  } cfg_fields_t;

  function automatic logic [SH_W-1:0] trailing_zeros(input logic [WORD_W-1:0] m);
    logic [SH_W-1:0] n;
    n = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (m[i]) n = SH_W'(i);
    end
    return n;
  endfunction

  function automatic logic [LVL_W-1:0] extract(input logic [WORD_W-1:0] word,
                                               input logic [WORD_W-1:0] mask,
                                               input logic [SH_W-1:0]   sh);
    logic [WORD_W-1:0] t;
    t = (word & mask) >> sh;
    return t[LVL_W-1:0];
  endfunction

  function automatic logic [CH_W-1:0] wrap_start(input logic [START_W-1:0] s);
    logic [15:0] v;
    v = 16'(s);
    for (int j = 8; j >= 0; j--) begin
      if ((CHANNELS << j) < (1 << START_W)) begin
        if (v >= 16'(CHANNELS << j)) v = v - 16'(CHANNELS << j);
      end
    end
    return v[CH_W-1:0];
  endfunction

  function automatic logic [CH_W-1:0] wrap_inc(input logic [CH_W-1:0] idx);
    logic [CH_W-1:0] r;
    if (idx == CH_W'(CHANNELS - 1)) r = '0;
    else r = idx + CH_W'(1);
    return r;
  endfunction

  function automatic logic [OUT_IDX_W-1:0] out_index(input logic [CH_W-1:0] idx);
    logic [15:0] t;
    t = 16'(idx);
    return t[OUT_IDX_W-1:0];
  endfunction

endpackage

[hdl/pcf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pcf_cfg_regs
// Field mask registers behind the APB-style port, with their shift amounts.
// ----------------------------------------------------------------------------
module pcf_cfg_regs import pcf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [WORD_W-1:0] cfg_pwdata,
  output logic [WORD_W-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_fields_t       cfg
);

  cfg_fields_t cfg_r;
  reg_idx_t    idx;
  logic        wr_en;
  logic [SH_W-1:0] wr_sh;

  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign wr_sh      = trailing_zeros(cfg_pwdata);
  assign cfg        = cfg_r;

  always_comb begin
    unique case (idx)
      REG_RED:   cfg_prdata = cfg_r.red_bits;
      REG_GREEN: cfg_prdata = cfg_r.green_bits;
      REG_BLUE:  cfg_prdata = cfg_r.blue_bits;
      default:   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red_bits   <= RED_MASK_RST;
      cfg_r.green_bits <= GREEN_MASK_RST;
      cfg_r.blue_bits  <= BLUE_MASK_RST;
      cfg_r.red_sh     <= trailing_zeros(RED_MASK_RST);
      cfg_r.green_sh   <= trailing_zeros(GREEN_MASK_RST);
      cfg_r.blue_sh    <= trailing_zeros(BLUE_MASK_RST);
    end else if (wr_en) begin
      unique case (idx)
        REG_RED: begin
          cfg_r.red_bits <= cfg_pwdata;
          cfg_r.red_sh   <= wr_sh;
        end
        REG_GREEN: begin
          cfg_r.green_bits <= cfg_pwdata;
          cfg_r.green_sh   <= wr_sh;
        end
        REG_BLUE: begin
          cfg_r.blue_bits <= cfg_pwdata;
          cfg_r.blue_sh   <= wr_sh;
        end
        default: ;
      endcase
    end
  end

endmodule

[hdl/pcf_level_ram.sv]
// ----------------------------------------------------------------------------
// pcf_level_ram
// Channel level memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pcf_level_ram import pcf_pkg::*; (
  input  logic             clk,
  input  logic             re,
  input  logic [CH_W-1:0]  raddr,
  output logic [LVL_W-1:0] rdata,
  input  logic             we,
  input  logic [CH_W-1:0]  waddr,
  input  logic [LVL_W-1:0] wdata
);

  logic [LVL_W-1:0] mem [CHANNELS];
  logic [LVL_W-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

endmodule

[hdl/pcf_fade_pipe.sv]
// ----------------------------------------------------------------------------
// pcf_fade_pipe
// Pixel holding stage, per-channel read/modify/write sequencer, slew update,
// output register and the level memory clearing pass after reset.
// ----------------------------------------------------------------------------
module pcf_fade_pipe import pcf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_fields_t          cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_op,
  input  logic [WORD_W-1:0]    in_pixel_word,
  input  logic [START_W-1:0]   in_start_channel,
  input  logic [LVL_W-1:0]     in_fade_step,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_IDX_W-1:0] out_channel_index,
  output logic [LVL_W-1:0]     out_level,
  output logic                 out_changed,
  output logic                 out_last,
  output logic                 mem_re,
  output logic [CH_W-1:0]      mem_raddr,
  input  logic [LVL_W-1:0]     mem_rdata,
  output logic                 mem_we,
  output logic [CH_W-1:0]      mem_waddr,
  output logic [LVL_W-1:0]     mem_wdata
);

  // clearing pass
  logic            clr_active_r;
  logic [CH_W-1:0] clr_addr_r;

  // pixel holding stage
  logic             item_vld_r, item_vld_nxt;
  logic [LVL_W-1:0] tgt_r [TGT_N];
  logic [K_W-1:0]   cnt_r;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [CH_W-1:0]  idx_r, idx_nxt;
  logic [LVL_W-1:0] step_r;

  // update stage
  logic             s2_vld_r;
  logic [CH_W-1:0]  s2_idx_r;
  logic [LVL_W-1:0] s2_tgt_r;
  logic [LVL_W-1:0] s2_step_r;
  logic             s2_last_r;

  // last write, for a read that overlaps it
  logic             wr_vld_r;
  logic [CH_W-1:0]  wr_idx_r;
  logic [LVL_W-1:0] wr_lvl_r;

  logic                 out_valid_r;
  logic [OUT_IDX_W-1:0] out_idx_r;
  logic [LVL_W-1:0]     out_lvl_r;
  logic                 out_chg_r;
  logic                 out_last_r;

  logic             accept, load;
  logic             s2_fire, s2_free, issue, issue_last;
  logic [LVL_W-1:0] old_lvl, new_lvl, gap;
  logic             up, snap;
  op_t              op;

  assign op         = op_t'(in_op);
  assign s2_fire    = s2_vld_r & (~out_valid_r | ~out_stall);
  assign s2_free    = ~s2_vld_r | s2_fire;
  assign issue      = item_vld_r & s2_free;
  assign issue_last = issue & (k_r == cnt_r);
  assign in_stall   = clr_active_r | (item_vld_r & ~issue_last);
  assign accept     = in_valid & ~in_stall;
  assign load       = accept & (op != OP_NONE);

  assign mem_re    = issue;
  assign mem_raddr = idx_r;

  // slew update
  assign old_lvl = (wr_vld_r && wr_idx_r == s2_idx_r) ? wr_lvl_r : mem_rdata;
  assign up      = s2_tgt_r > old_lvl;
  assign gap     = up ? (s2_tgt_r - old_lvl) : (old_lvl - s2_tgt_r);
  assign snap    = (s2_step_r == '0) || ({1'b0, gap} < {s2_step_r, 1'b0});
  assign new_lvl = snap ? s2_tgt_r : (up ? old_lvl + s2_step_r : old_lvl - s2_step_r);

  assign mem_we    = clr_active_r | s2_fire;
  assign mem_waddr = clr_active_r ? clr_addr_r : s2_idx_r;
  assign mem_wdata = clr_active_r ? '0 : new_lvl;

  always_comb begin
    item_vld_nxt = item_vld_r;
    k_nxt        = k_r;
    idx_nxt      = idx_r;
    if (issue) begin
      k_nxt   = k_r + K_W'(1);
      idx_nxt = wrap_inc(idx_r);
    end
    if (issue_last) item_vld_nxt = 1'b0;
    if (load) begin
      item_vld_nxt = 1'b1;
      k_nxt        = '0;
      idx_nxt      = wrap_start(in_start_channel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= wrap_inc(clr_addr_r);
      if (clr_addr_r == CH_W'(CHANNELS - 1)) clr_active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      k_r        <= '0;
    end else begin
      item_vld_r <= item_vld_nxt;
      k_r        <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (load) begin
      step_r <= in_fade_step;
      unique case (op)
        OP_GREY: begin
          cnt_r    <= K_W'(0);
          tgt_r[0] <= extract(in_pixel_word, cfg.green_bits, cfg.green_sh);
          tgt_r[1] <= '0;
          tgt_r[2] <= '0;
          tgt_r[3] <= '0;
        end
        OP_RGB: begin
          cnt_r    <= K_W'(2);
          tgt_r[0] <= extract(in_pixel_word, cfg.red_bits, cfg.red_sh);
          tgt_r[1] <= extract(in_pixel_word, cfg.green_bits, cfg.green_sh);
          tgt_r[2] <= extract(in_pixel_word, cfg.blue_bits, cfg.blue_sh);
          tgt_r[3] <= '0;
        end
        default: begin
          cnt_r    <= K_W'(3);
          tgt_r[0] <= ALPHA_FULL;
          tgt_r[1] <= extract(in_pixel_word, cfg.red_bits, cfg.red_sh);
          tgt_r[2] <= extract(in_pixel_word, cfg.green_bits, cfg.green_sh);
          tgt_r[3] <= extract(in_pixel_word, cfg.blue_bits, cfg.blue_sh);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_free) begin
      s2_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_idx_r  <= idx_r;
      s2_tgt_r  <= tgt_r[k_r];
      s2_step_r <= step_r;
      s2_last_r <= (k_r == cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_vld_r <= 1'b0;
    end else if (s2_fire) begin
      wr_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      wr_idx_r <= s2_idx_r;
      wr_lvl_r <= new_lvl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_idx_r  <= out_index(s2_idx_r);
      out_lvl_r  <= new_lvl;
      out_chg_r  <= (s2_tgt_r != old_lvl);
      out_last_r <= s2_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel_index = out_idx_r;
  assign out_level         = out_lvl_r;
  assign out_changed       = out_chg_r;
  assign out_last          = out_last_r;

endmodule

[hdl/pixel_to_channel_fader_top.sv]
// ----------------------------------------------------------------------------
// pixel_to_channel_fader_top
// Pixel words in, slew-limited channel levels out.
// ----------------------------------------------------------------------------
// Each pixel beat yields one result beat per channel it drives: one for grey,
// three for rgb, four for argb, none for the unused format. Results leave at
// one beat per cycle while out_stall is low; a new pixel is taken in the cycle
// its last channel enters the update stage. The level memory does one read
// and one write back per channel; the first result beat of a pixel passes the
// pixel holding stage, the update stage and the output register.
// After reset the memory is cleared one entry per cycle, so no pixel is taken
// until all 512 entries are cleared; mask registers may be written meanwhile.
// ----------------------------------------------------------------------------
module pixel_to_channel_fader_top import pcf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [ADDR_W-1:0]    cfg_paddr,
  input  logic [WORD_W-1:0]    cfg_pwdata,
  output logic [WORD_W-1:0]    cfg_prdata,
  output logic                 cfg_pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_op,
  input  logic [WORD_W-1:0]    in_pixel_word,
  input  logic [START_W-1:0]   in_start_channel,
  input  logic [LVL_W-1:0]     in_fade_step,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_IDX_W-1:0] out_channel_index,
  output logic [LVL_W-1:0]     out_level,
  output logic                 out_changed,
  output logic                 out_last
);

  cfg_fields_t      cfg;
  logic             mem_re, mem_we;
  logic [CH_W-1:0]  mem_raddr, mem_waddr;
  logic [LVL_W-1:0] mem_rdata, mem_wdata;

  pcf_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pcf_level_ram u_ram (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  pcf_fade_pipe u_pipe (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_pixel_word     (in_pixel_word),
    .in_start_channel  (in_start_channel),
    .in_fade_step      (in_fade_step),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_channel_index (out_channel_index),
    .out_level         (out_level),
    .out_changed       (out_changed),
    .out_last          (out_last),
    .mem_re            (mem_re),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata)
  );

endmodule

[sim/pixel_to_channel_fader_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_to_channel_fader_checker
// Watches the pixel, result and mask-register ports of the fader and checks
// every result beat against its own model of the channel level store.
// ----------------------------------------------------------------------------
module pixel_to_channel_fader_checker import pcf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic                 cfg_pready,
  input  logic [ADDR_W-1:0]    cfg_paddr,
  input  logic [WORD_W-1:0]    cfg_pwdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [1:0]           in_op,
  input  logic [WORD_W-1:0]    in_pixel_word,
  input  logic [START_W-1:0]   in_start_channel,
  input  logic [LVL_W-1:0]     in_fade_step,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [OUT_IDX_W-1:0] out_channel_index,
  input  logic [LVL_W-1:0]     out_level,
  input  logic                 out_changed,
  input  logic                 out_last,
  output int                   fail_count,
  output int                   reports_due
);

  typedef struct {
    logic [OUT_IDX_W-1:0] channel_index;
    logic [LVL_W-1:0]     level;
    logic                 changed;
    logic                 last;
  } level_report_t;

  level_report_t     level_reports[$];
  logic [LVL_W-1:0]  channel_level [CHANNELS];
  logic [WORD_W-1:0] red_bits;
  logic [WORD_W-1:0] green_bits;
  logic [WORD_W-1:0] blue_bits;

  function automatic logic [LVL_W-1:0] field_value(input logic [WORD_W-1:0] word,
                                                   input logic [WORD_W-1:0] mask);
    logic [WORD_W-1:0] m;
    logic [WORD_W-1:0] t;
    m = mask;
    t = word & mask;
    if (m != '0) begin
      while (!m[0]) begin
        m = m >> 1;
        t = t >> 1;
      end
    end
    return t[LVL_W-1:0];
  endfunction

  function automatic logic [LVL_W-1:0] fade_toward(input logic [LVL_W-1:0] cur,
                                                   input logic [LVL_W-1:0] tgt,
                                                   input logic [LVL_W-1:0] step);
    int gap;
    gap = int'(tgt) - int'(cur);
    if (gap < 0) gap = -gap;
    if (step == '0 || gap <= int'(step) || gap - int'(step) < int'(step)) return tgt;
    if (tgt > cur) return cur + step;
    return cur - step;
  endfunction

  task automatic fade_pixel(input op_t op, input logic [WORD_W-1:0] word,
                            input logic [START_W-1:0] start,
                            input logic [LVL_W-1:0] step);
    logic [LVL_W-1:0] targets [TGT_N];
    logic [LVL_W-1:0] old_level;
    level_report_t    rep;
    int               n;
    int               ch;
    n = 0;
    case (op)
      OP_GREY: begin
        targets[0] = field_value(word, green_bits);
        n = 1;
      end
      OP_RGB: begin
        targets[0] = field_value(word, red_bits);
        targets[1] = field_value(word, green_bits);
        targets[2] = field_value(word, blue_bits);
        n = 3;
      end
      OP_ARGB: begin
        targets[0] = ALPHA_FULL;
        targets[1] = field_value(word, red_bits);
        targets[2] = field_value(word, green_bits);
        targets[3] = field_value(word, blue_bits);
        n = 4;
      end
      default: n = 0;
    endcase
    for (int k = 0; k < n; k++) begin
      ch = (int'(start) + k) % CHANNELS;
      old_level = channel_level[ch];
      channel_level[ch] = fade_toward(old_level, targets[k], step);
      rep.channel_index = OUT_IDX_W'(ch);
      rep.level = channel_level[ch];
      rep.changed = (targets[k] != old_level);
      rep.last = (k == n - 1);
      level_reports.push_back(rep);
    end
  endtask

  always @(posedge clk) begin
    level_report_t exp_rep;
    if (!rst_n) begin
      red_bits = RED_MASK_RST;
      green_bits = GREEN_MASK_RST;
      blue_bits = BLUE_MASK_RST;
      for (int i = 0; i < CHANNELS; i++) channel_level[i] = '0;
      level_reports.delete();
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_RED:   red_bits = cfg_pwdata;
          REG_GREEN: green_bits = cfg_pwdata;
          REG_BLUE:  blue_bits = cfg_pwdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        fade_pixel(op_t'(in_op), in_pixel_word, in_start_channel, in_fade_step);
      if (out_valid && !out_stall) begin
        if (level_reports.size() == 0) begin
          $error("result beat with nothing expected: channel_index %0d level %0d",
                 out_channel_index, out_level);
          fail_count++;
        end else begin
          exp_rep = level_reports.pop_front();
          if (out_channel_index !== exp_rep.channel_index) begin
            $error("channel_index: expected %0d, actual %0d",
                   exp_rep.channel_index, out_channel_index);
            fail_count++;
          end
          if (out_level !== exp_rep.level) begin
            $error("level: expected %0d, actual %0d", exp_rep.level, out_level);
            fail_count++;
          end
          if (out_changed !== exp_rep.changed) begin
            $error("changed: expected %0b, actual %0b", exp_rep.changed, out_changed);
            fail_count++;
          end
          if (out_last !== exp_rep.last) begin
            $error("last: expected %0b, actual %0b", exp_rep.last, out_last);
            fail_count++;
          end
        end
      end
    end
    reports_due = level_reports.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Pixel stimulus, mask settings and flow control for the channel fader.
// ----------------------------------------------------------------------------
// A short directed run covers jumps, slewing, snapping, wrap of the channel
// index and the ignored format; four random phases follow, each with its own
// mask setting and its own mix of sender gaps and receiver stalls. The
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
  import pcf_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE      = 10;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]    cfg_paddr = '0;
  logic [WORD_W-1:0]    cfg_pwdata = '0;
  logic [WORD_W-1:0]    cfg_prdata;
  logic                 cfg_pready;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_op = '0;
  logic [WORD_W-1:0]    in_pixel_word = '0;
  logic [START_W-1:0]   in_start_channel = '0;
  logic [LVL_W-1:0]     in_fade_step = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OUT_IDX_W-1:0] out_channel_index;
  logic [LVL_W-1:0]     out_level;
  logic                 out_changed;
  logic                 out_last;

  int fail_count;
  int reports_due;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int hold_cnt = 0;

  pixel_to_channel_fader_top dut (.*);

  pixel_to_channel_fader_checker checker_i (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr,
    .cfg_pwdata, .in_valid, .in_stall, .in_op, .in_pixel_word, .in_start_channel,
    .in_fade_step, .out_valid, .out_stall, .out_channel_index, .out_level,
    .out_changed, .out_last, .fail_count, .reports_due
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_mask(input reg_idx_t idx, input logic [WORD_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_W'({idx, 2'b00});
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_masks(input logic [WORD_W-1:0] red, input logic [WORD_W-1:0] green,
                           input logic [WORD_W-1:0] blue);
    write_mask(REG_RED, red);
    write_mask(REG_GREEN, green);
    write_mask(REG_BLUE, blue);
  endtask

  task automatic send_pixel(input op_t op, input logic [WORD_W-1:0] word,
                            input logic [START_W-1:0] start,
                            input logic [LVL_W-1:0] step);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_pixel_word <= word;
    in_start_channel <= start;
    in_fade_step <= step;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    while (reports_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [WORD_W-1:0] random_field_mask;
    int w;
    int p;
    w = $urandom_range(12, 1);
    p = $urandom_range(32 - w);
    return WORD_W'(((64'd1 << w) - 64'd1) << p);
  endfunction

  task automatic send_random(input int count);
    op_t               op;
    logic [WORD_W-1:0] word;
    logic [START_W-1:0] start;
    logic [LVL_W-1:0]  step;
    int                r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      op = (r < 8) ? OP_NONE : (r < 35) ? OP_GREY : (r < 65) ? OP_RGB : OP_ARGB;
      r = $urandom_range(99);
      if (r < 70) start = START_W'($urandom_range(15));
      else if (r < 85) start = START_W'($urandom_range(511, 504));
      else start = START_W'($urandom_range(511));
      r = $urandom_range(99);
      if (r < 15) step = '0;
      else if (r < 30) step = 8'hff;
      else if (r < 60) step = LVL_W'($urandom_range(8, 1));
      else step = LVL_W'($urandom_range(255));
      r = $urandom_range(99);
      if (r < 10) word = '0;
      else if (r < 20) word = '1;
      else word = $urandom;
      send_pixel(op, word, start, step);
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_masks(RED_MASK_RST, GREEN_MASK_RST, BLUE_MASK_RST);
    write_mask(REG_NONE, 32'h1234_5678);

    send_pixel(OP_GREY, 32'h0000_ab00, 9'd0, 8'd0);
    send_pixel(OP_GREY, 32'h0000_ab00, 9'd0, 8'd0);
    send_pixel(OP_RGB,  32'hffff_ffff, 9'd511, 8'd0);
    send_pixel(OP_ARGB, 32'h0000_0000, 9'd510, 8'd0);
    send_pixel(OP_NONE, 32'hffff_ffff, 9'd5, 8'd9);
    send_pixel(OP_GREY, 32'h0000_ff00, 9'd100, 8'd10);
    send_pixel(OP_GREY, 32'h0000_ff00, 9'd100, 8'd10);
    send_pixel(OP_GREY, 32'h0000_1a00, 9'd100, 8'd10);
    send_pixel(OP_GREY, 32'h0000_3000, 9'd100, 8'd10);
    send_pixel(OP_GREY, 32'h0000_3000, 9'd100, 8'd10);
    send_pixel(OP_GREY, 32'h0000_0000, 9'd100, 8'd255);
    send_pixel(OP_GREY, 32'h0000_ff00, 9'd101, 8'd1);
    send_pixel(OP_GREY, 32'h0000_0000, 9'd101, 8'd1);
    send_pixel(OP_ARGB, 32'hffff_ffff, 9'd200, 8'd100);
    send_pixel(OP_ARGB, 32'hffff_ffff, 9'd200, 8'd100);
    send_pixel(OP_RGB,  32'h0012_3456, 9'd300, 8'd0);
    send_pixel(OP_RGB,  32'h0000_0000, 9'd300, 8'd1);
    send_pixel(OP_RGB,  32'h5555_5555, 9'h155, 8'haa);
    send_pixel(OP_ARGB, 32'haaaa_aaaa, 9'h0aa, 8'h55);

    hold_req <= 1'b1;
    send_random(25);
    drain_results;

    set_masks(32'h0000_0000, 32'hffff_ffff, 32'h8000_0000);
    send_idle_pct <= 67;
    recv_stall_pct <= 0;
    send_random(25);
    drain_results;

    set_masks(random_field_mask(), random_field_mask(), random_field_mask());
    send_idle_pct <= 0;
    recv_stall_pct <= 67;
    send_random(25);
    drain_results;

    set_masks($urandom, $urandom, random_field_mask());
    send_idle_pct <= 16;
    recv_stall_pct <= 16;
    send_random(25);
    drain_results;

    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
